[hdl/vsi_pkg.sv]
// ----------------------------------------------------------------------------
// vsi_pkg
// Shared widths, constants, types and the arctangent table for the
// 4-vector spherical interpolation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vsi_pkg;

  localparam int CompW        = 16;  // vector component width, Q2.14
  localparam int FracW        = 14;
  localparam int TW           = 15;  // blend factor / threshold width
  localparam int CordicStages = 16;
  localparam int StW          = 5;   // stage index width
  localparam int RadW         = 62;  // square root radicand
  localparam int SqStages     = RadW / 2;
  localparam int RootW        = RadW / 2;
  localparam int CrdW         = 34;  // CORDIC datapath
  localparam int AngW         = 32;  // angle in [0, pi], 30 fraction bits
  localparam int ProdW        = 51;
  localparam int NumW         = 54;
  localparam int DenW         = 32;
  localparam int QW           = 17;  // quotient bits, top bit flags overflow

  localparam logic signed [CrdW-1:0] AngPi         = 34'sd3373259426;
  localparam logic signed [CrdW-1:0] AngHalfPi     = 34'sd1686629713;
  localparam logic signed [CrdW-1:0] CordicInvGain = 34'sd652032874;
  localparam logic [TW-1:0]          OneQ14        = 15'd16384;
  localparam logic [TW-1:0]          ThrReset      = 15'd16;

  // per-item context carried down the pipe
  typedef struct packed {
    logic [3:0][CompW-1:0] sv;
    logic [3:0][CompW:0]   dv;
    logic [3:0][CrdW-1:0]  lv;
    logic [TW-1:0]         t;
    logic                  sp;
    logic                  lin;
    logic [CrdW-1:0]       c;
    logic [RootW-1:0]      s;
  } ctx_t;

  // sign and path info that rides along the divider
  typedef struct packed {
    logic [3:0] neg;
    logic       zero;
    logic       lin;
  } fin_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic [CrdW-1:0] atan_entry(input logic [StW-1:0] i);
    logic [CrdW-1:0] v;
    case (i)
      5'd0:    v = 34'd843314856;
      5'd1:    v = 34'd497837829;
      5'd2:    v = 34'd263043836;
      5'd3:    v = 34'd133525158;
      5'd4:    v = 34'd67021686;
      5'd5:    v = 34'd33543515;
      5'd6:    v = 34'd16775850;
      5'd7:    v = 34'd8388437;
      5'd8:    v = 34'd4194282;
      5'd9:    v = 34'd2097149;
      5'd10:   v = 34'd1048575;
      default: v = (i < 5'd30) ? ((CrdW'(1) << (30 - int'(i))) - CrdW'(1)) : '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[hdl/vsi_in_if.sv]
// ----------------------------------------------------------------------------
// vsi_in_if
// Input channel: source and destination vectors, blend factor, path flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface vsi_in_if;
  import vsi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [CompW-1:0] src_x;
  logic signed [CompW-1:0] src_y;
  logic signed [CompW-1:0] src_z;
  logic signed [CompW-1:0] src_w;
  logic signed [CompW-1:0] dst_x;
  logic signed [CompW-1:0] dst_y;
  logic signed [CompW-1:0] dst_z;
  logic signed [CompW-1:0] dst_w;
  logic [TW-1:0]           blend_factor;
  logic                    shortest_path;

  modport source (output valid, src_x, src_y, src_z, src_w, dst_x, dst_y, dst_z,
                  dst_w, blend_factor, shortest_path, input ready);
  modport sink   (input valid, src_x, src_y, src_z, src_w, dst_x, dst_y, dst_z,
                  dst_w, blend_factor, shortest_path, output ready);
endinterface

`default_nettype wire

[hdl/vsi_out_if.sv]
// ----------------------------------------------------------------------------
// vsi_out_if
// Output channel: interpolated vector and path flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface vsi_out_if;
  import vsi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [CompW-1:0] out_x;
  logic signed [CompW-1:0] out_y;
  logic signed [CompW-1:0] out_z;
  logic signed [CompW-1:0] out_w;
  logic                    used_linear;

  modport source (output valid, out_x, out_y, out_z, out_w, used_linear, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, used_linear, output ready);
endinterface

`default_nettype wire

[hdl/vsi_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// vsi_sqrt_cell
// One digit step of the exact integer square root, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module vsi_sqrt_cell (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [vsi_pkg::StW-1:0]   stage_i,
  input  logic [vsi_pkg::RadW-1:0]  rem_i,
  input  logic [vsi_pkg::RadW-1:0]  root_i,
  output logic [vsi_pkg::RadW-1:0]  rem_o,
  output logic [vsi_pkg::RadW-1:0]  root_o
);
  import vsi_pkg::*;

  logic [RadW-1:0] bit_w, trial, rem_d, root_d, rem_q, root_q;

  always_comb begin
    bit_w = RadW'(1) << (RadW - 2 - 2 * int'(stage_i));
    trial = root_i + bit_w;
    if (rem_i >= trial) begin
      rem_d  = rem_i - trial;
      root_d = (root_i >> 1) + bit_w;
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

[hdl/vsi_cordic_cell.sv]
// ----------------------------------------------------------------------------
// vsi_cordic_cell
// One CORDIC micro-rotation, vectoring or rotation mode, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module vsi_cordic_cell (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic                            vec_mode_i,
  input  logic [vsi_pkg::StW-1:0]         stage_i,
  input  logic signed [vsi_pkg::CrdW-1:0] x_i,
  input  logic signed [vsi_pkg::CrdW-1:0] y_i,
  input  logic signed [vsi_pkg::CrdW-1:0] z_i,
  output logic signed [vsi_pkg::CrdW-1:0] x_o,
  output logic signed [vsi_pkg::CrdW-1:0] y_o,
  output logic signed [vsi_pkg::CrdW-1:0] z_o
);
  import vsi_pkg::*;

  logic signed [CrdW-1:0] xs, ys, at, x_d, y_d, z_d, x_q, y_q, z_q;
  logic                   ccw;

  always_comb begin
    xs  = x_i >>> stage_i;
    ys  = y_i >>> stage_i;
    at  = $signed(atan_entry(stage_i));
    // vectoring drives y to zero, rotation drives z to zero
    ccw = vec_mode_i ? y_i[CrdW-1] : ~z_i[CrdW-1];
    if (ccw) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - at;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

`default_nettype wire

[hdl/vsi_div_cell.sv]
// ----------------------------------------------------------------------------
// vsi_div_cell
// One restoring-division quotient bit, registered; carries the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module vsi_div_cell (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [vsi_pkg::StW-1:0]   stage_i,
  input  logic [vsi_pkg::NumW-1:0]  rem_i,
  input  logic [vsi_pkg::QW-1:0]    quo_i,
  input  logic [vsi_pkg::DenW-1:0]  den_i,
  output logic [vsi_pkg::NumW-1:0]  rem_o,
  output logic [vsi_pkg::QW-1:0]    quo_o,
  output logic [vsi_pkg::DenW-1:0]  den_o
);
  import vsi_pkg::*;

  logic [NumW-1:0] dsh, rem_d, rem_q;
  logic [QW-1:0]   quo_d, quo_q;
  logic [DenW-1:0] den_q;
  logic            ge;

  always_comb begin
    dsh   = NumW'(den_i) << stage_i;
    ge    = rem_i >= dsh;
    rem_d = ge ? (rem_i - dsh) : rem_i;
    quo_d = quo_i | (QW'(ge) << stage_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      den_q <= den_i;
    end
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign den_o = den_q;

endmodule

`default_nettype wire

[hdl/vec4_spherical_interpolation.sv]
// ----------------------------------------------------------------------------
// vec4_spherical_interpolation
// Fixed-point slerp of two Q2.14 4-vectors, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  item_i    in   src_x..src_w, dst_x..dst_w, blend_factor, shortest_path
//  res_o     out  out_x..out_w, used_linear
//  cfg       in   cfg_we_i / cfg_wdata_i: near_threshold
//
//  One beat per cycle in, one per cycle out unless res_o stalls; depth is set by the
//  31-cell square root chain, the 16-cell CORDIC chains and the 17-cell divider.
//  A stalled output freezes the whole pipe; item_i.ready = res_o.ready | ~res_o.valid.
//  Reset clears the valid chain and loads near_threshold with 16.
// ----------------------------------------------------------------------------
`default_nettype none

module vec4_spherical_interpolation (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [vsi_pkg::TW-1:0] cfg_wdata_i,
  vsi_in_if.sink                item_i,
  vsi_out_if.source             res_o
);
  import vsi_pkg::*;

  localparam int Lat = 6 + SqStages + 1 + CordicStages + 3 + CordicStages + 4 + QW + 1;

  logic [TW-1:0]  thr_q;
  logic [Lat-1:0] vld_q;
  logic           pipe_en;

  assign pipe_en      = ~vld_q[Lat-1] | res_o.ready;
  assign item_i.ready = pipe_en;
  assign res_o.valid  = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
      vld_q <= '0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (pipe_en)  vld_q <= {vld_q[Lat-2:0], item_i.valid};
    end
  end

  // A: capture
  ctx_t a_ctx_d, a_ctx_q;
  always_comb begin
    a_ctx_d       = '0;
    a_ctx_d.sv[0] = item_i.src_x;
    a_ctx_d.sv[1] = item_i.src_y;
    a_ctx_d.sv[2] = item_i.src_z;
    a_ctx_d.sv[3] = item_i.src_w;
    a_ctx_d.dv[0] = (CompW+1)'(item_i.dst_x);
    a_ctx_d.dv[1] = (CompW+1)'(item_i.dst_y);
    a_ctx_d.dv[2] = (CompW+1)'(item_i.dst_z);
    a_ctx_d.dv[3] = (CompW+1)'(item_i.dst_w);
    a_ctx_d.t     = (item_i.blend_factor > OneQ14) ? OneQ14 : item_i.blend_factor;
    a_ctx_d.sp    = item_i.shortest_path;
  end

  // B: dot product terms
  ctx_t                    b_ctx_q;
  logic signed [2*CompW-1:0] b_prod_d [4];
  logic signed [2*CompW-1:0] b_prod_q [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      b_prod_d[k] = $signed(a_ctx_q.sv[k]) * $signed(a_ctx_q.dv[k][CompW-1:0]);
    end
  end

  // C: sum, shortest path flip, path decision
  ctx_t                   c_ctx_d, c_ctx_q;
  logic signed [CrdW-1:0] sum_c, cval;
  logic [CrdW-1:0]        ac_c;
  logic signed [CompW:0]  bnd;
  logic signed [35:0]     ac_s, bound_s;
  logic                   flip;
  always_comb begin
    c_ctx_d = b_ctx_q;
    sum_c   = '0;
    for (int k = 0; k < 4; k++) sum_c = sum_c + CrdW'(b_prod_q[k]);
    flip = b_ctx_q.sp & sum_c[CrdW-1];
    cval = flip ? -sum_c : sum_c;
    for (int k = 0; k < 4; k++) begin
      c_ctx_d.dv[k] = flip ? -b_ctx_q.dv[k] : b_ctx_q.dv[k];
    end
    ac_c    = cval[CrdW-1] ? -cval : cval;
    bnd     = $signed({2'b00, OneQ14}) - $signed({2'b00, thr_q});
    ac_s    = $signed({2'b00, ac_c});
    bound_s = 36'($signed({bnd, {FracW{1'b0}}}));
    // |c| of exactly one leaves no sine to divide by
    c_ctx_d.lin = (ac_s > bound_s) || (ac_c == (CrdW'(1) << (2 * FracW)));
    c_ctx_d.c   = cval;
  end

  // D: c squared, linear blend
  ctx_t                   d_ctx_d, d_ctx_q;
  logic [CrdW-1:0]        ac_d;
  logic [57:0]            sq_d, d_sq_q;
  logic signed [17:0]     diff_w [4];
  logic signed [CrdW-1:0] mul_w [4];
  logic signed [CrdW-1:0] base_w [4];
  always_comb begin
    d_ctx_d = c_ctx_q;
    ac_d    = c_ctx_q.c[CrdW-1] ? -c_ctx_q.c : c_ctx_q.c;
    sq_d    = ac_d[28:0] * ac_d[28:0];
    for (int k = 0; k < 4; k++) begin
      diff_w[k] = $signed(c_ctx_q.dv[k]) - $signed(c_ctx_q.sv[k]);
      mul_w[k]  = diff_w[k] * $signed({1'b0, c_ctx_q.t});
      base_w[k] = $signed(c_ctx_q.sv[k]);
      d_ctx_d.lv[k] = (base_w[k] <<< FracW) + mul_w[k];
    end
  end

  // E: squares of the linear blend, 1 - c^2
  ctx_t               e_ctx_q;
  logic [RadW-1:0]    ll_d [4];
  logic [RadW-1:0]    e_ll_q [4];
  logic [56:0]        e_rad_d, e_rad_q;
  logic signed [30:0] lsmall [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lsmall[k] = $signed(d_ctx_q.lv[k][30:0]);
      ll_d[k]   = lsmall[k] * lsmall[k];
    end
    e_rad_d = (57'd1 << (4 * FracW)) - 57'(d_sq_q);
  end

  // F: radicand select
  ctx_t            f_ctx_q;
  logic [RadW-1:0] f_rad_d, f_rad_q;
  always_comb begin
    f_rad_d = e_ll_q[0] + e_ll_q[1] + e_ll_q[2] + e_ll_q[3];
    if (!e_ctx_q.lin) f_rad_d = RadW'(e_rad_q);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      a_ctx_q <= a_ctx_d;
      b_ctx_q <= a_ctx_q;
      for (int k = 0; k < 4; k++) b_prod_q[k] <= b_prod_d[k];
      c_ctx_q <= c_ctx_d;
      d_ctx_q <= d_ctx_d;
      d_sq_q  <= sq_d;
      e_ctx_q <= d_ctx_q;
      for (int k = 0; k < 4; k++) e_ll_q[k] <= ll_d[k];
      e_rad_q <= e_rad_d;
      f_ctx_q <= e_ctx_q;
      f_rad_q <= f_rad_d;
    end
  end

  // square root chain
  logic [RadW-1:0] sqv [SqStages+1];
  logic [RadW-1:0] sqr [SqStages+1];
  ctx_t            sq_ctx_q [SqStages];
  assign sqv[0] = f_rad_q;
  assign sqr[0] = '0;

  for (genvar g = 0; g < SqStages; g++) begin : g_sqrt
    vsi_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (pipe_en),
      .stage_i (StW'(g)),
      .rem_i   (sqv[g]),
      .root_i  (sqr[g]),
      .rem_o   (sqv[g+1]),
      .root_o  (sqr[g+1])
    );
  end

  // G: vector (c, s) into the right half plane
  ctx_t                   g_ctx_d, g_ctx_q;
  logic signed [CrdW-1:0] x0, y0, g_x_d, g_y_d, g_z_d, g_x_q, g_y_q, g_z_q;
  always_comb begin
    g_ctx_d   = sq_ctx_q[SqStages-1];
    g_ctx_d.s = sqr[SqStages][RootW-1:0];
    x0 = $signed(g_ctx_d.c) <<< 2;
    y0 = $signed(CrdW'({g_ctx_d.s, 2'b00}));
    if (x0[CrdW-1]) begin
      g_x_d = y0;
      g_y_d = -x0;
      g_z_d = AngHalfPi;
    end else begin
      g_x_d = x0;
      g_y_d = y0;
      g_z_d = '0;
    end
  end

  // vectoring chain
  logic signed [CrdW-1:0] vx [CordicStages+1];
  logic signed [CrdW-1:0] vy [CordicStages+1];
  logic signed [CrdW-1:0] vz [CordicStages+1];
  ctx_t                   vc_ctx_q [CordicStages];
  assign vx[0] = g_x_q;
  assign vy[0] = g_y_q;
  assign vz[0] = g_z_q;

  for (genvar g = 0; g < CordicStages; g++) begin : g_vec
    vsi_cordic_cell u_cell (
      .clk_i      (clk_i),
      .en_i       (pipe_en),
      .vec_mode_i (1'b1),
      .stage_i    (StW'(g)),
      .x_i        (vx[g]),
      .y_i        (vy[g]),
      .z_i        (vz[g]),
      .x_o        (vx[g+1]),
      .y_o        (vy[g+1]),
      .z_o        (vz[g+1])
    );
  end

  // H: clamp theta to [0, pi]
  ctx_t              h_ctx_q;
  logic [AngW-1:0]   h_theta_d, h_theta_q;
  always_comb begin
    if (vz[CordicStages][CrdW-1])          h_theta_d = '0;
    else if (vz[CordicStages] > AngPi)     h_theta_d = AngW'(AngPi);
    else                                   h_theta_d = AngW'(vz[CordicStages]);
  end

  // I: split theta by t
  ctx_t             i_ctx_q;
  logic [46:0]      mul_a, mul_b;
  logic [AngW-1:0]  i_ang_d [2];
  logic [AngW-1:0]  i_ang_q [2];
  always_comb begin
    mul_a      = h_theta_q * (OneQ14 - h_ctx_q.t);
    mul_b      = h_theta_q * h_ctx_q.t;
    i_ang_d[0] = mul_a[AngW+FracW-1:FracW];
    i_ang_d[1] = mul_b[AngW+FracW-1:FracW];
  end

  // J: fold into the first quadrant
  ctx_t                   j_ctx_q;
  logic signed [CrdW-1:0] phi_w [2];
  logic signed [CrdW-1:0] j_phi_d [2];
  logic signed [CrdW-1:0] j_phi_q [2];
  always_comb begin
    for (int n = 0; n < 2; n++) begin
      phi_w[n]   = $signed(CrdW'(i_ang_q[n]));
      j_phi_d[n] = (phi_w[n] > AngHalfPi) ? (AngPi - phi_w[n]) : phi_w[n];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sq_ctx_q[0] <= f_ctx_q;
      for (int k = 1; k < SqStages; k++) sq_ctx_q[k] <= sq_ctx_q[k-1];
      g_ctx_q <= g_ctx_d;
      g_x_q   <= g_x_d;
      g_y_q   <= g_y_d;
      g_z_q   <= g_z_d;
      vc_ctx_q[0] <= g_ctx_q;
      for (int k = 1; k < CordicStages; k++) vc_ctx_q[k] <= vc_ctx_q[k-1];
      h_ctx_q   <= vc_ctx_q[CordicStages-1];
      h_theta_q <= h_theta_d;
      i_ctx_q   <= h_ctx_q;
      j_ctx_q   <= i_ctx_q;
      for (int n = 0; n < 2; n++) begin
        i_ang_q[n] <= i_ang_d[n];
        j_phi_q[n] <= j_phi_d[n];
      end
    end
  end

  // rotation chains: lane 0 gives sin(a), lane 1 gives sin(b)
  logic signed [CrdW-1:0] rx [2][CordicStages+1];
  logic signed [CrdW-1:0] ry [2][CordicStages+1];
  logic signed [CrdW-1:0] rz [2][CordicStages+1];
  ctx_t                   rc_ctx_q [CordicStages];

  for (genvar n = 0; n < 2; n++) begin : g_rot_lane
    assign rx[n][0] = CordicInvGain;
    assign ry[n][0] = '0;
    assign rz[n][0] = j_phi_q[n];
    for (genvar g = 0; g < CordicStages; g++) begin : g_rot
      vsi_cordic_cell u_cell (
        .clk_i      (clk_i),
        .en_i       (pipe_en),
        .vec_mode_i (1'b0),
        .stage_i    (StW'(g)),
        .x_i        (rx[n][g]),
        .y_i        (ry[n][g]),
        .z_i        (rz[n][g]),
        .x_o        (rx[n][g+1]),
        .y_o        (ry[n][g+1]),
        .z_o        (rz[n][g+1])
      );
    end
  end

  // K: weight the two vectors
  ctx_t                    k_ctx_q;
  logic signed [ProdW-1:0] k_pa_d [4];
  logic signed [ProdW-1:0] k_pb_d [4];
  logic signed [ProdW-1:0] k_pa_q [4];
  logic signed [ProdW-1:0] k_pb_q [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      k_pa_d[k] = $signed(rc_ctx_q[CordicStages-1].sv[k]) * ry[0][CordicStages];
      k_pb_d[k] = $signed(rc_ctx_q[CordicStages-1].dv[k]) * ry[1][CordicStages];
    end
  end

  // L: numerator and divisor per path
  logic signed [NumW-1:0] l_num_d [4];
  logic signed [NumW-1:0] l_num_q [4];
  logic [DenW-1:0]        l_den_d, l_den_q;
  fin_t                   l_fin_d, l_fin_q;
  always_comb begin
    l_fin_d.lin  = k_ctx_q.lin;
    l_fin_d.zero = k_ctx_q.lin && (k_ctx_q.s == '0);
    l_den_d      = k_ctx_q.lin ? DenW'(k_ctx_q.s) : DenW'({k_ctx_q.s, 2'b00});
    for (int k = 0; k < 4; k++) begin
      if (k_ctx_q.lin) begin
        l_num_d[k] = $signed(k_ctx_q.lv[k]);
        l_num_d[k] = l_num_d[k] <<< FracW;
      end else begin
        l_num_d[k] = k_pa_q[k] + k_pb_q[k];
      end
      l_fin_d.neg[k] = l_num_d[k][NumW-1];
    end
  end

  // M: magnitude, N: add half divisor for rounding
  logic [NumW-1:0] m_mag_q [4];
  logic [DenW-1:0] m_den_q;
  fin_t            m_fin_q;
  logic [NumW-1:0] n_u_q [4];
  logic [DenW-1:0] n_den_q;
  fin_t            n_fin_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      rc_ctx_q[0] <= j_ctx_q;
      for (int k = 1; k < CordicStages; k++) rc_ctx_q[k] <= rc_ctx_q[k-1];
      k_ctx_q <= rc_ctx_q[CordicStages-1];
      l_den_q <= l_den_d;
      l_fin_q <= l_fin_d;
      m_den_q <= l_den_q;
      m_fin_q <= l_fin_q;
      n_den_q <= m_den_q;
      n_fin_q <= m_fin_q;
      for (int k = 0; k < 4; k++) begin
        k_pa_q[k]  <= k_pa_d[k];
        k_pb_q[k]  <= k_pb_d[k];
        l_num_q[k] <= l_num_d[k];
        m_mag_q[k] <= l_num_q[k][NumW-1] ? NumW'(-l_num_q[k]) : NumW'(l_num_q[k]);
        n_u_q[k]   <= m_mag_q[k] + NumW'(m_den_q >> 1);
      end
    end
  end

  // divider lanes, quotient MSB first
  logic [NumW-1:0] dr [4][QW+1];
  logic [QW-1:0]   dq [4][QW+1];
  logic [DenW-1:0] dd [4][QW+1];
  fin_t            dv_fin_q [QW];

  for (genvar n = 0; n < 4; n++) begin : g_div_lane
    assign dr[n][0] = n_u_q[n];
    assign dq[n][0] = '0;
    assign dd[n][0] = n_den_q;
    for (genvar g = 0; g < QW; g++) begin : g_div
      vsi_div_cell u_cell (
        .clk_i   (clk_i),
        .en_i    (pipe_en),
        .stage_i (StW'(QW - 1 - g)),
        .rem_i   (dr[n][g]),
        .quo_i   (dq[n][g]),
        .den_i   (dd[n][g]),
        .rem_o   (dr[n][g+1]),
        .quo_o   (dq[n][g+1]),
        .den_o   (dd[n][g+1])
      );
    end
  end

  // O: sign, saturate
  fin_t                    fin_w;
  logic [QW-1:0]           q_w [4];
  logic signed [CompW-1:0] o_out_d [4];
  logic signed [CompW-1:0] o_out_q [4];
  logic                    o_lin_q;
  always_comb begin
    fin_w = dv_fin_q[QW-1];
    for (int k = 0; k < 4; k++) begin
      q_w[k] = dq[k][QW];
      if (fin_w.zero) begin
        o_out_d[k] = '0;
      end else if (fin_w.neg[k]) begin
        if (q_w[k] > QW'(1 << (CompW - 1))) o_out_d[k] = {1'b1, {(CompW-1){1'b0}}};
        else                                o_out_d[k] = -$signed(q_w[k][CompW-1:0]);
      end else begin
        if (q_w[k] > QW'((1 << (CompW - 1)) - 1)) o_out_d[k] = {1'b0, {(CompW-1){1'b1}}};
        else                                      o_out_d[k] = $signed(q_w[k][CompW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dv_fin_q[0] <= n_fin_q;
      for (int k = 1; k < QW; k++) dv_fin_q[k] <= dv_fin_q[k-1];
      for (int k = 0; k < 4; k++) o_out_q[k] <= o_out_d[k];
      o_lin_q <= fin_w.lin;
    end
  end

  assign res_o.out_x       = o_out_q[0];
  assign res_o.out_y       = o_out_q[1];
  assign res_o.out_z       = o_out_q[2];
  assign res_o.out_w       = o_out_q[3];
  assign res_o.used_linear = o_lin_q;

endmodule

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 4-vector slerp pipeline. Random and directed
// vector pairs go in through a queue-fed driver, each accepted beat is
// predicted by a bit-exact fixed-point slerp model, and the monitor compares
// every output beat in order. The near-parallel threshold is swept between
// phases, including zero, one and the 15-bit maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vsi_pkg::*;

  typedef struct {
    logic [3:0][CompW-1:0] src;
    logic [3:0][CompW-1:0] dst;
    logic [TW-1:0]         t;
    logic                  sp;
  } vec_pair_t;

  typedef struct {
    logic [3:0][CompW-1:0] v;
    logic                  lin;
  } blend_t;

  localparam longint AngPiL   = 64'sd3373259426;
  localparam longint AngHalfL = 64'sd1686629713;
  localparam longint InvGainL = 64'sd652032874;
  localparam int     Latency  = 100;
  localparam int     CycLimit = 600000;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [TW-1:0] cfg_wdata_i;

  vsi_in_if  in_ch();
  vsi_out_if out_ch();

  vec4_spherical_interpolation dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (in_ch),
    .res_o       (out_ch)
  );

  vec_pair_t pending_pairs[$];
  blend_t    expected_blends[$];
  longint    thr_shadow;
  int        mismatches;
  int        cycles;
  logic      in_fire, out_fire;
  bit        burst_mode;
  bit        hold_req;
  int        hold_left;

  // ---------------- slerp predictor ----------------
  function automatic longint arctan_step(int i);
    longint head[11] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                         33543515, 16775850, 8388437, 4194282, 2097149, 1048575};
    if (i < 11) return head[i];
    if (i < 30) return (64'sd1 << (30 - i)) - 1;
    return 0;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint unsigned u, q;
    u = (num < 0) ? longint'(-num) : num;
    q = (u + longint'(den) / 2) / longint'(den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [CompW-1:0] clamp_q14(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[CompW-1:0];
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, tmp, xs, ys;
    z = 0;
    if (x < 0) begin
      tmp = x; x = y; y = -tmp; z = AngHalfL;
    end
    for (int i = 0; i < CordicStages; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += arctan_step(i);
      end else begin
        x -= ys; y += xs; z -= arctan_step(i);
      end
    end
    if (z < 0) z = 0;
    if (z > AngPiL) z = AngPiL;
    return z;
  endfunction

  function automatic longint rotate_sine(longint phi);
    longint x, y, z, xs, ys;
    x = InvGainL;
    y = 0;
    if (phi > AngHalfL) phi = AngPiL - phi;
    z = phi;
    for (int i = 0; i < CordicStages; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan_step(i);
      end else begin
        x += ys; y -= xs; z += arctan_step(i);
      end
    end
    return y;
  endfunction

  function automatic blend_t slerp_predict(vec_pair_t p);
    longint sv[4], dv[4], lv[4];
    longint c, tt, bound, ac, s28, theta, sa, sb;
    longint unsigned sumsq, len;
    blend_t r;
    tt = p.t;
    if (tt > 16384) tt = 16384;
    c = 0;
    for (int k = 0; k < 4; k++) begin
      sv[k] = $signed(p.src[k]);
      dv[k] = $signed(p.dst[k]);
      c += sv[k] * dv[k];
    end
    if (p.sp && c < 0) begin
      for (int k = 0; k < 4; k++) dv[k] = -dv[k];
      c = -c;
    end
    bound = (16384 - thr_shadow) * 16384;
    ac = (c < 0) ? -c : c;
    r.lin = ac > bound;
    s28 = 0;
    if (!r.lin) begin
      s28 = int_sqrt((64'd1 << 56) - longint'(c * c));
      if (s28 == 0) r.lin = 1'b1;
    end
    if (r.lin) begin
      sumsq = 0;
      for (int k = 0; k < 4; k++) begin
        lv[k] = sv[k] * 16384 + (dv[k] - sv[k]) * tt;
        sumsq += longint'(lv[k] * lv[k]);
      end
      len = int_sqrt(sumsq);
      for (int k = 0; k < 4; k++)
        r.v[k] = (len == 0) ? '0 : clamp_q14(round_div(lv[k] * 16384, len));
    end else begin
      theta = vector_angle(c * 4, s28 * 4);
      sa = rotate_sine((theta * (16384 - tt)) >>> 14);
      sb = rotate_sine((theta * tt) >>> 14);
      for (int k = 0; k < 4; k++)
        r.v[k] = clamp_q14(round_div(sv[k] * sa + dv[k] * sb, s28 * 4));
    end
    return r;
  endfunction

  // ---------------- stimulus shaping ----------------
  function automatic logic [3:0][CompW-1:0] unit_vec(real scale);
    real f[4], n;
    logic [3:0][CompW-1:0] v;
    do begin
      n = 0.0;
      for (int k = 0; k < 4; k++) begin
        f[k] = real'(int'($urandom_range(0, 65535)) - 32768);
        n += f[k] * f[k];
      end
    end while (n < 1.0);
    n = $sqrt(n);
    for (int k = 0; k < 4; k++) v[k] = clamp_q14(longint'($rtoi(f[k] / n * scale)));
    return v;
  endfunction

  function automatic vec_pair_t rand_pair();
    vec_pair_t p;
    int kind, jit;
    kind = $urandom_range(0, 9);
    jit = $urandom_range(0, 3) == 0 ? 2000 : 60;
    p.src = unit_vec(16384.0);
    case (kind)
      0, 1, 2, 3: p.dst = unit_vec(16384.0);
      4, 5: begin  // near parallel / antiparallel
        for (int k = 0; k < 4; k++)
          p.dst[k] = clamp_q14(($urandom_range(0, 1) ? 1 : -1) * 0 +
                     (kind == 4 ? 1 : -1) * longint'($signed(p.src[k])) +
                     int'($urandom_range(0, 2 * jit)) - jit);
      end
      6: p.dst = p.src;
      7: begin
        p.src = unit_vec(real'($urandom_range(1000, 30000)));
        p.dst = unit_vec(real'($urandom_range(1000, 30000)));
      end
      default: begin
        for (int k = 0; k < 4; k++) begin
          p.src[k] = CompW'($urandom);
          p.dst[k] = CompW'($urandom);
        end
      end
    endcase
    p.t = ($urandom_range(0, 9) == 0) ? TW'($urandom) : TW'($urandom_range(0, 16384));
    p.sp = 1'($urandom_range(0, 1));
    return p;
  endfunction

  function automatic vec_pair_t fixed_pair(logic [15:0] s0, logic [15:0] d0,
                                           logic [15:0] sr, logic [15:0] dr,
                                           logic [TW-1:0] t, logic sp);
    vec_pair_t p;
    p.src = {sr, sr, sr, s0};
    p.dst = {dr, dr, dr, d0};
    p.t = t;
    p.sp = sp;
    return p;
  endfunction

  // ---------------- clock, reset ----------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycLimit) begin
      $display("[vec4_spherical_interpolation] ERROR");
      $finish;
    end
  end

  // ---------------- driver ----------------
  int in_gap;
  always @(negedge clk_i) begin
    vec_pair_t p;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else if (!in_ch.valid || in_fire) begin
      if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap--;
      end else if (pending_pairs.size() > 0) begin
        p = pending_pairs.pop_front();
        in_ch.src_x <= p.src[0]; in_ch.src_y <= p.src[1];
        in_ch.src_z <= p.src[2]; in_ch.src_w <= p.src[3];
        in_ch.dst_x <= p.dst[0]; in_ch.dst_y <= p.dst[1];
        in_ch.dst_z <= p.dst[2]; in_ch.dst_w <= p.dst[3];
        in_ch.blend_factor  <= p.t;
        in_ch.shortest_path <= p.sp;
        in_ch.valid <= 1'b1;
        in_gap = burst_mode ? 0 : $urandom_range(0, 13);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // accept side: predict on every input beat
  always @(posedge clk_i) begin
    vec_pair_t p;
    in_fire  <= in_ch.valid && in_ch.ready;
    out_fire <= out_ch.valid && out_ch.ready;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      p.src = {in_ch.src_w, in_ch.src_z, in_ch.src_y, in_ch.src_x};
      p.dst = {in_ch.dst_w, in_ch.dst_z, in_ch.dst_y, in_ch.dst_x};
      p.t   = in_ch.blend_factor;
      p.sp  = in_ch.shortest_path;
      expected_blends.push_back(slerp_predict(p));
    end
  end

  // ---------------- receiver ----------------
  always @(negedge clk_i) begin
    if (!rst_ni) hold_left = 0;
    else if (hold_req && hold_left == 0) hold_left = 400;
    else if (hold_left > 1) hold_left--;
  end

  int out_stall;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_fire) out_stall = burst_mode ? 0 : $urandom_range(0, 13);
      else if (out_stall > 0) out_stall--;
      out_ch.ready <= (out_stall == 0) && (hold_left <= 1);
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin
    blend_t e;
    logic [3:0][CompW-1:0] got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = {out_ch.out_w, out_ch.out_z, out_ch.out_y, out_ch.out_x};
      if (expected_blends.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat %h lin=%b", got,
                                       out_ch.used_linear);
      end else begin
        e = expected_blends.pop_front();
        if (got !== e.v || out_ch.used_linear !== e.lin) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h lin=%b, got %h lin=%b", e.v, e.lin, got,
                     out_ch.used_linear);
        end
      end
    end
  end

  // ---------------- sequence ----------------
  task automatic drain_pipe();
    while (pending_pairs.size() != 0 || in_ch.valid || expected_blends.size() != 0)
      @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic set_threshold(logic [TW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = val;
    @(posedge clk_i);
    thr_shadow = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    logic [TW-1:0] thr_list[6] = '{15'd16, 15'd0, 15'd32767, 15'd16384, 15'd500, 15'd16};
    cycles = 0;
    mismatches = 0;
    thr_shadow = 16;
    burst_mode = 0;
    hold_req = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.src_x = '0; in_ch.src_y = '0; in_ch.src_z = '0; in_ch.src_w = '0;
    in_ch.dst_x = '0; in_ch.dst_y = '0; in_ch.dst_z = '0; in_ch.dst_w = '0;
    in_ch.blend_factor = '0;
    in_ch.shortest_path = 1'b0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, at reset threshold
    pending_pairs.push_back(fixed_pair(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 15'd8192, 1));
    pending_pairs.push_back(fixed_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000, 15'd0, 0));
    pending_pairs.push_back(fixed_pair(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 15'd16384, 0));
    pending_pairs.push_back(fixed_pair(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 15'd16384, 1));
    pending_pairs.push_back(fixed_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'd4000, 1));
    // opposite unit vectors halfway: zero-length linear blend
    pending_pairs.push_back(fixed_pair(16'd16384, -16'sd16384, 16'h0, 16'h0, 15'd8192, 0));
    pending_pairs.push_back(fixed_pair(16'd16384, 16'd16384, 16'h0, 16'h0, 15'd8192, 0));
    pending_pairs.push_back(fixed_pair(16'd16384, 16'h0, 16'h0, 16'h0, 15'd8192, 0));
    pending_pairs.push_back(fixed_pair(16'd16384, 16'h0, 16'h0, 16'h0, 15'd0, 0));
    pending_pairs.push_back(fixed_pair(16'd16384, 16'h0, 16'h0, 16'h0, 15'd16384, 1));
    pending_pairs.push_back(fixed_pair(16'd16384, 16'h0, 16'h0, 16'h0, 15'h7fff, 0));
    pending_pairs.push_back(fixed_pair(16'd16384, -16'sd11585, 16'h0, 16'd11585, 15'd5000, 1));
    pending_pairs.push_back(fixed_pair(16'd16384, -16'sd11585, 16'h0, 16'd11585, 15'd5000, 0));
    pending_pairs.push_back(fixed_pair(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 15'h2aaa, 1));
    drain_pipe();

    foreach (thr_list[ph]) begin
      set_threshold(thr_list[ph]);
      // exact dot of one: with zero margin this falls through to linear
      pending_pairs.push_back(fixed_pair(16'd16384, 16'd16384, 16'h0, 16'h0, 15'd3000, 0));
      for (int n = 0; n < 190; n++) pending_pairs.push_back(rand_pair());
      if (ph == 1) hold_req = 1;
      burst_mode = (ph == 3);
      repeat (300) @(posedge clk_i);
      hold_req = 0;
      drain_pipe();
    end

    if (mismatches == 0) begin
      $display("[vec4_spherical_interpolation] OK");
    end else begin
      $display("[vec4_spherical_interpolation] ERROR");
    end
    $finish;
  end

  final begin
    if (expected_blends.size() != 0) mismatches++;
  end

endmodule

`default_nettype wire
